[rtl/core/rsbd_pkg.sv]
// ----------------------------------------------------------------------------
// rsbd_pkg
// shared types and constants of the run-length sprite blit decoder
// ----------------------------------------------------------------------------
package rsbd_pkg;

    localparam int ADDR_W   = 20;
    localparam int PIXA_W   = 20;
    localparam int COL_W    = 16;
    localparam int ROW_W    = 16;
    localparam int CFG_AW   = 5;

    localparam logic [7:0] CODE_SKIP_RUN = 8'd255;
    localparam logic [7:0] CODE_NEWLINE  = 8'd254;
    localparam logic [7:0] CODE_SKIP_ONE = 8'd253;

    localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [2:0] REG_LINE_PITCH    = 3'd2;
    localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd3;
    localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] base_address;
        logic [11:0]       line_pitch;
        logic [9:0]        sprite_width;
        logic [9:0]        sprite_height;
    } cfg_t;

endpackage

[rtl/core/rle_sprite_blit_decoder_top.sv]
// ----------------------------------------------------------------------------
// rle_sprite_blit_decoder_top
// run-length sprite byte stream to framebuffer pixel write decoder
// ----------------------------------------------------------------------------
// Takes one coded sprite byte per request and returns exactly one result per
// byte: a pixel write flag, address and colour, and a done flag. A byte
// enters an input register and is decoded against the cursor state into the
// result register once that register is free or being drained, so a new
// byte is taken every clock cycle while results are consumed. The start
// flag on s_tuser loads the base address origin_y * line_pitch + origin_x,
// which is registered from the configuration in the cycle after the last
// register write.
module rle_sprite_blit_decoder_top
    import rsbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // shape_byte
    input  logic              s_tuser,   // first
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // pixel_address[19:0], pixel_color[27:20]
    output logic [1:0]        m_tuser    // write_enable[0], done_res[1]
);

    cfg_t              cfg;
    logic              out_we;
    logic [PIXA_W-1:0] out_addr;
    logic [7:0]        out_color;
    logic              out_done;

    rsbd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rsbd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_first  (s_tuser),
        .in_byte   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_we    (out_we),
        .out_addr  (out_addr),
        .out_color (out_color),
        .out_done  (out_done)
    );

    assign m_tdata = {4'd0, out_color, out_addr};
    assign m_tuser = {out_done, out_we};

endmodule

[rtl/core/rsbd_cfg.sv]
// ----------------------------------------------------------------------------
// rsbd_cfg
// register file behind the apb port, plus the registered sprite base address
// ----------------------------------------------------------------------------
module rsbd_cfg
    import rsbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [9:0]        origin_x_reg;
    logic [9:0]        origin_y_reg;
    logic [11:0]       line_pitch_reg;
    logic [9:0]        sprite_width_reg;
    logic [9:0]        sprite_height_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] base_next;
    logic [21:0]       product;
    logic              wr_en;
    logic [2:0]        reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= 10'd0;
            origin_y_reg      <= 10'd0;
            line_pitch_reg    <= 12'd320;
            sprite_width_reg  <= 10'd1;
            sprite_height_reg <= 10'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_ORIGIN_X:      origin_x_reg      <= pwdata[9:0];
                REG_ORIGIN_Y:      origin_y_reg      <= pwdata[9:0];
                REG_LINE_PITCH:    line_pitch_reg    <= pwdata[11:0];
                REG_SPRITE_WIDTH:  sprite_width_reg  <= pwdata[9:0];
                REG_SPRITE_HEIGHT: sprite_height_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_ORIGIN_X:      prdata = {22'd0, origin_x_reg};
            REG_ORIGIN_Y:      prdata = {22'd0, origin_y_reg};
            REG_LINE_PITCH:    prdata = {20'd0, line_pitch_reg};
            REG_SPRITE_WIDTH:  prdata = {22'd0, sprite_width_reg};
            REG_SPRITE_HEIGHT: prdata = {22'd0, sprite_height_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // origin_y * line_pitch + origin_x, kept ready for the start marker
    assign product   = 22'(origin_y_reg) * 22'(line_pitch_reg);
    assign base_next = ADDR_W'(product) + ADDR_W'(origin_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    assign cfg.base_address  = base_reg;
    assign cfg.line_pitch    = line_pitch_reg;
    assign cfg.sprite_width  = sprite_width_reg;
    assign cfg.sprite_height = sprite_height_reg;

endmodule

[rtl/core/rsbd_core.sv]
// ----------------------------------------------------------------------------
// rsbd_core
// input register, byte decode with cursor state, and result register
// ----------------------------------------------------------------------------
module rsbd_core
    import rsbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_first,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_we,
    output logic [PIXA_W-1:0] out_addr,
    output logic [7:0]        out_color,
    output logic              out_done
);

    logic              in_valid_reg;
    logic              first_reg;
    logic [7:0]        byte_reg;

    logic [COL_W-1:0]  column_reg;
    logic [COL_W-1:0]  column_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              pending_reg;
    logic              pending_next;
    logic              finished_reg;
    logic              finished_next;
    logic [ADDR_W-1:0] address_reg;
    logic [ADDR_W-1:0] address_next;

    logic              out_valid_reg;
    logic              we_reg;
    logic              we_next;
    logic [PIXA_W-1:0] pixa_reg;
    logic [PIXA_W-1:0] pixa_next;
    logic [7:0]        color_reg;
    logic [7:0]        color_next;
    logic              done_reg;

    logic              fire;

    assign fire     = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            first_reg <= in_first;
            byte_reg  <= in_byte;
        end
    end

    always_comb
    begin
        column_next   = column_reg;
        row_next      = row_reg;
        pending_next  = pending_reg;
        finished_next = finished_reg;
        address_next  = address_reg;
        we_next       = 1'b0;
        pixa_next     = '0;
        color_next    = 8'd0;

        if (first_reg)
        begin
            column_next   = '0;
            row_next      = '0;
            pending_next  = 1'b0;
            address_next  = cfg.base_address;
            finished_next = (cfg.sprite_height == 10'd0);
        end

        if (!finished_next)
        begin
            priority if (pending_next)
            begin
                pending_next = 1'b0;
                address_next = address_next + ADDR_W'(byte_reg);
                column_next  = column_next + COL_W'(byte_reg);
            end
            else if (byte_reg == CODE_SKIP_RUN)
            begin
                pending_next = 1'b1;
            end
            else if (byte_reg == CODE_NEWLINE)
            begin
                address_next = address_next - ADDR_W'(column_next)
                             + ADDR_W'(cfg.line_pitch);
                column_next  = '0;
                row_next     = row_next + ROW_W'(1);
            end
            else if (byte_reg == CODE_SKIP_ONE)
            begin
                address_next = address_next + ADDR_W'(1);
                column_next  = column_next + COL_W'(1);
            end
            else
            begin
                we_next      = 1'b1;
                pixa_next    = PIXA_W'(address_next);
                color_next   = byte_reg;
                address_next = address_next + ADDR_W'(1);
                column_next  = column_next + COL_W'(1);
            end

            // row wrap on exact width match
            if (column_next == COL_W'(cfg.sprite_width))
            begin
                address_next = address_next - ADDR_W'(column_next)
                             + ADDR_W'(cfg.line_pitch);
                column_next  = '0;
                row_next     = row_next + ROW_W'(1);
            end
            finished_next = (row_next >= ROW_W'(cfg.sprite_height));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            pending_reg   <= 1'b0;
            finished_reg  <= 1'b1;
            address_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                column_reg   <= column_next;
                row_reg      <= row_next;
                pending_reg  <= pending_next;
                finished_reg <= finished_next;
                address_reg  <= address_next;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            we_reg    <= we_next;
            pixa_reg  <= pixa_next;
            color_reg <= color_next;
            done_reg  <= finished_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_we    = we_reg;
    assign out_addr  = pixa_reg;
    assign out_color = color_reg;
    assign out_done  = done_reg;

endmodule
